### src/gbt_pkg.sv
package gbt_pkg;

	// Field and register widths.
	localparam int DIM_W      = 13;
	localparam int COLOR_W    = 24;
	localparam int CHAN_W     = 8;
	localparam int FRAC_W     = 16;
	localparam int NUM_CH     = 3;
	localparam int ACC_W      = CHAN_W + FRAC_W;
	localparam int NUM_W      = CHAN_W + FRAC_W;
	localparam int STEP_W     = NUM_W + 1;
	localparam int DIV_STEPS  = NUM_W;
	localparam int PIXEL_W    = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = COLOR_W;
	localparam int MIN_DIM    = 2;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hff;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_START_COLOR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_COLOR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

	// Command carried through the queue.
	typedef enum logic {
		CMD_ADVANCE = 1'b0,
		CMD_RESTART = 1'b1
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_head_t;

	typedef struct packed {
		logic               start;
		logic [COLOR_W-1:0] start_color;
		logic [COLOR_W-1:0] end_color;
		logic [DIM_W-1:0]   divisor;
	} div_req_t;

	typedef logic [NUM_CH-1:0][STEP_W-1:0] step_vec_t;

	typedef struct packed {
		logic      busy;
		step_vec_t steps;
	} div_stat_t;

	// Channel 0 is red in the top byte, channel 2 is blue in the bottom byte.
	function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] color,
			input int unsigned idx);
		return color[(NUM_CH - 1 - idx) * CHAN_W +: CHAN_W];
	endfunction

	// One and a half times the value, saturated.
	function automatic logic [CHAN_W-1:0] lighten(input logic [CHAN_W-1:0] v);
		logic [CHAN_W:0] sum;
		sum = {1'b0, v} + {2'b00, v[CHAN_W-1:1]};
		return sum[CHAN_W] ? '1 : sum[CHAN_W-1:0];
	endfunction

	// Three quarters of the value with both halvings truncated.
	function automatic logic [CHAN_W-1:0] darken(input logic [CHAN_W-1:0] v);
		return {1'b0, v[CHAN_W-1:1]} + {2'b00, v[CHAN_W-1:2]};
	endfunction

endpackage

### src/gbt_front.sv
module gbt_front import gbt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      restart,
	input  logic      pop,
	output cmd_head_t head
);

	localparam int DEPTH = 2;

	cmd_t       mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	// Classify each transfer into a command and queue it.
	assign in_ready   = (count_q != 2'(DEPTH));
	assign push       = in_valid && in_ready;
	assign head.valid = (count_q != 2'd0);
	assign head.cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= restart ? CMD_RESTART : CMD_ADVANCE;
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(DEPTH))
		else $error("queue fill level exceeds its depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0)
		else $error("queue popped while empty");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 2'd1)
		else $error("queue fill level did not grow on push");

endmodule

### src/gbt_divider.sv
module gbt_divider import gbt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  div_req_t  req,
	output div_stat_t stat
);

	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIM_W-1:0]   div_q;
	logic [NUM_W-1:0]   num_q [NUM_CH];
	logic [DIM_W-1:0]   rem_q [NUM_CH];
	logic [NUM_W-1:0]   quo_q [NUM_CH];
	logic               neg_q [NUM_CH];
	step_vec_t          steps_q;

	logic [DIM_W:0]     trial   [NUM_CH];
	logic [DIM_W:0]     reduced [NUM_CH];
	logic               fits    [NUM_CH];
	logic [DIM_W-1:0]   rem_nx  [NUM_CH];
	logic [NUM_W-1:0]   quo_nx  [NUM_CH];
	logic [STEP_W-1:0]  step_nx [NUM_CH];
	logic [CHAN_W-1:0]  s_ch    [NUM_CH];
	logic [CHAN_W-1:0]  e_ch    [NUM_CH];
	logic               neg_st  [NUM_CH];
	logic [CHAN_W-1:0]  mag_st  [NUM_CH];

	// One restoring quotient bit per cycle in each of the three lanes.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			trial[c]   = {rem_q[c], num_q[c][NUM_W-1]};
			reduced[c] = trial[c] - {1'b0, div_q};
			fits[c]    = (trial[c] >= {1'b0, div_q});
			rem_nx[c]  = fits[c] ? reduced[c][DIM_W-1:0] : trial[c][DIM_W-1:0];
			quo_nx[c]  = {quo_q[c][NUM_W-2:0], fits[c]};
			step_nx[c] = neg_q[c] ? (STEP_W'(0) - {1'b0, quo_nx[c]}) : {1'b0, quo_nx[c]};
			s_ch[c]    = chan_of(req.start_color, c);
			e_ch[c]    = chan_of(req.end_color, c);
			neg_st[c]  = (e_ch[c] < s_ch[c]);
			mag_st[c]  = neg_st[c] ? (s_ch[c] - e_ch[c]) : (e_ch[c] - s_ch[c]);
		end
	end

	// Operand and partial result registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.divisor;
			for (int c = 0; c < NUM_CH; c++) begin
				num_q[c] <= {mag_st[c], FRAC_W'(0)};
				rem_q[c] <= '0;
				quo_q[c] <= '0;
				neg_q[c] <= neg_st[c];
			end
		end else if (busy_q) begin
			for (int c = 0; c < NUM_CH; c++) begin
				num_q[c] <= {num_q[c][NUM_W-2:0], 1'b0};
				rem_q[c] <= rem_nx[c];
				quo_q[c] <= quo_nx[c];
			end
		end
	end

	// Sequencing and the finished steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			steps_q <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
					for (int c = 0; c < NUM_CH; c++) begin
						steps_q[c] <= step_nx[c];
					end
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	assign stat.busy  = busy_q;
	assign stat.steps = steps_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("divider did not start on request");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !req.start && cnt_q == CNT_LAST |=> !busy_q)
		else $error("divider ran past its last step");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> cnt_q == '0)
		else $error("divider step count not cleared while idle");

endmodule

### src/gbt_back.sv
module gbt_back import gbt_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_head_t             head,
	output logic                  pop,
	output div_req_t              div_req,
	input  div_stat_t             div_stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIXEL_W-1:0]    pixel_word,
	output logic                  end_of_row,
	output logic                  end_of_frame
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WXW = ((CW > DIM_W) ? CW : DIM_W) + 1;
	localparam int HXW = ((RW > DIM_W) ? RW : DIM_W) + 1;
	localparam logic [WXW-1:0] W_MAX = WXW'(MAX_WIDTH);
	localparam logic [WXW-1:0] W_MIN = WXW'(MIN_DIM);
	localparam logic [HXW-1:0] H_MAX = HXW'(MAX_HEIGHT);
	localparam logic [HXW-1:0] H_MIN = HXW'(MIN_DIM);

	logic [COLOR_W-1:0] start_color_q;
	logic [COLOR_W-1:0] end_color_q;
	logic [DIM_W-1:0]   frame_width_q;
	logic [DIM_W-1:0]   frame_height_q;

	logic [CW-1:0]      col_q;
	logic [RW-1:0]      row_q;
	logic [ACC_W-1:0]   acc_q [NUM_CH];

	logic               out_valid_q;
	logic [PIXEL_W-1:0] pixel_word_q;
	logic               end_of_row_q;
	logic               end_of_frame_q;

	logic [WXW-1:0]     fw_x;
	logic [WXW-1:0]     w_cl;
	logic [HXW-1:0]     fh_x;
	logic [HXW-1:0]     h_cl;
	logic               is_restart;
	logic [CW-1:0]      col_e;
	logic [RW-1:0]      row_e;
	logic               last_col;
	logic               last_row;
	logic               row_adv;
	logic               wrap;
	logic               fire;
	logic [ACC_W-1:0]   start_acc [NUM_CH];
	logic [ACC_W-1:0]   acc_e     [NUM_CH];
	logic [CHAN_W-1:0]  ch        [NUM_CH];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_color_q  <= '0;
			end_color_q    <= '0;
			frame_width_q  <= DIM_W'(64);
			frame_height_q <= DIM_W'(64);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_START_COLOR:  start_color_q  <= cfg_data[COLOR_W-1:0];
				REG_END_COLOR:    end_color_q    <= cfg_data[COLOR_W-1:0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamped frame size, position of this pixel and its bevel class.
	always_comb begin
		fw_x       = WXW'(frame_width_q);
		w_cl       = (fw_x < W_MIN) ? W_MIN : ((fw_x > W_MAX) ? W_MAX : fw_x);
		fh_x       = HXW'(frame_height_q);
		h_cl       = (fh_x < H_MIN) ? H_MIN : ((fh_x > H_MAX) ? H_MAX : fh_x);
		is_restart = (head.cmd == CMD_RESTART);
		col_e      = is_restart ? '0 : col_q;
		row_e      = is_restart ? '0 : row_q;
		last_col   = (WXW'(col_e) >= (w_cl - WXW'(1)));
		last_row   = (HXW'(row_e) >= (h_cl - HXW'(1)));
		row_adv    = last_col && !last_row;
		wrap       = last_col && last_row;
	end

	// Row color and bevel for each channel.
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			start_acc[c] = {chan_of(start_color_q, c), FRAC_W'(0)};
			acc_e[c]     = is_restart ? start_acc[c] : acc_q[c];
			ch[c]        = acc_e[c][ACC_W-1 -: CHAN_W];
			if (row_e == '0) begin
				ch[c] = lighten(ch[c]);
			end else if (last_row) begin
				ch[c] = darken(ch[c]);
				if (col_e == '0) begin
					ch[c] = lighten(ch[c]);
				end
				if (last_col) begin
					ch[c] = darken(ch[c]);
				end
			end else begin
				if (col_e == '0) begin
					ch[c] = lighten(ch[c]);
				end else if (last_col) begin
					ch[c] = darken(ch[c]);
				end
			end
		end
	end

	// A row advance waits until the per-row steps are ready.
	assign fire = head.valid && (!out_valid_q || out_ready) && !(row_adv && div_stat.busy);
	assign pop  = fire;

	assign div_req.start       = fire && (is_restart || wrap);
	assign div_req.start_color = start_color_q;
	assign div_req.end_color   = end_color_q;
	assign div_req.divisor     = h_cl[DIM_W-1:0];

	// Raster position and row accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < NUM_CH; c++) begin
				acc_q[c] <= '0;
			end
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				if (!last_col) begin
					col_q <= col_e + CW'(1);
					row_q <= row_e;
					for (int c = 0; c < NUM_CH; c++) begin
						acc_q[c] <= acc_e[c];
					end
				end else if (!last_row) begin
					col_q <= '0;
					row_q <= row_e + RW'(1);
					for (int c = 0; c < NUM_CH; c++) begin
						acc_q[c] <= acc_e[c] + div_stat.steps[c][ACC_W-1:0];
					end
				end else begin
					col_q <= '0;
					row_q <= '0;
					for (int c = 0; c < NUM_CH; c++) begin
						acc_q[c] <= start_acc[c];
					end
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (fire) begin
			pixel_word_q   <= {ALPHA_OPAQUE, ch[0], ch[1], ch[2]};
			end_of_row_q   <= last_col;
			end_of_frame_q <= wrap;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_word   = pixel_word_q;
	assign end_of_row   = end_of_row_q;
	assign end_of_frame = end_of_frame_q;

	a_fire_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("pixel taken from the queue was not presented");

	a_wrap_divides: assert property (@(posedge clk) disable iff (!arst_n)
		fire && wrap |=> div_stat.busy)
		else $error("frame wrap did not start the step computation");

	a_frame_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && end_of_frame_q |-> end_of_row_q)
		else $error("frame end flagged off the end of a row");

endmodule

### src/gradient_bevel_texture_generator_top.sv
// Vertical gradient raster with a one-pixel bevel, one pixel per transfer.
// Each request passes through the command queue and then the output register before its
// pixel is presented.
// Throughput: one pixel per cycle while the output is ready; the row step after the first row
// of a frame waits for the serial divider started at the frame start, so a short first row stalls.
// Reset: asynchronous and active low; registers take their defaults and the raster restarts.
module gradient_bevel_texture_generator_top import gbt_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIXEL_W-1:0]    pixel_word,
	output logic                  end_of_row,
	output logic                  end_of_frame
);

	cmd_head_t head;
	logic      pop;
	div_req_t  div_req;
	div_stat_t div_stat;

	// Command queue between input and raster engine.
	gbt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.restart  (restart),
		.pop      (pop),
		.head     (head)
	);

	// Per-frame step computation.
	gbt_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat)
	);

	// Raster engine and output register.
	gbt_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.head         (head),
		.pop          (pop),
		.div_req      (div_req),
		.div_stat     (div_stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_word   (pixel_word),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

endmodule

### tb/sv/testbench.sv
module testbench;
	import gbt_pkg::*;

	localparam int MAX_DIM        = 4096;
	localparam int DRAIN_CYCLES   = 32;
	localparam int STALL_CYCLES   = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 100;
	localparam int LONG_RUN       = 150;

	// One predicted or observed pixel transfer.
	typedef struct packed {
		logic [PIXEL_W-1:0] word;
		logic               eor;
		logic               eof;
	} raster_pixel_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_write  = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic                  restart    = 1'b0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic [PIXEL_W-1:0]    pixel_word;
	logic                  end_of_row;
	logic                  end_of_frame;

	// Register copies and raster position as the generator should hold them.
	logic [COLOR_W-1:0] cfg_start  = '0;
	logic [COLOR_W-1:0] cfg_end    = '0;
	logic [DIM_W-1:0]   cfg_width  = 13'd64;
	logic [DIM_W-1:0]   cfg_height = 13'd64;
	int unsigned        col_pos    = 0;
	int unsigned        row_pos    = 0;
	logic [ACC_W-1:0]   row_level [NUM_CH];
	logic [STEP_W-1:0]  row_step  [NUM_CH];

	raster_pixel_t expected_pixels [$];
	raster_pixel_t oldest_pixel;
	int            pixels_checked = 0;
	int            mismatches     = 0;
	int unsigned   send_idle_pct  = 0;
	int unsigned   recv_idle_pct  = 0;
	int            stall_requests = 0;
	int            stalls_served  = 0;
	int            stall_left     = 0;
	int            quiet_cycles   = 0;

	gradient_bevel_texture_generator_top #(
		.MAX_WIDTH (MAX_DIM),
		.MAX_HEIGHT(MAX_DIM)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_word  (pixel_word),
		.end_of_row  (end_of_row),
		.end_of_frame(end_of_frame)
	);

	always #10 clk = ~clk;

	// Sizes outside the supported range are pinned to the nearest legal value.
	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
		if (v < MIN_DIM) return MIN_DIM;
		if (v > MAX_DIM) return MAX_DIM;
		return v;
	endfunction

	function automatic logic [7:0] brighten(input logic [7:0] v);
		int unsigned s;
		s = v + v / 2;
		return (s > 255) ? 8'd255 : s[7:0];
	endfunction

	function automatic logic [7:0] shade(input logic [7:0] v);
		return v / 2 + v / 4;
	endfunction

	// Frame start: load each channel with its start value and divide the span by the height.
	task automatic reload_gradient();
		int unsigned height_eff;
		int unsigned s;
		int unsigned e;
		logic [31:0] quot;
		logic [31:0] neg;
		height_eff = clamp_dim(cfg_height);
		for (int c = 0; c < NUM_CH; c++) begin
			s = cfg_start[COLOR_W-1-CHAN_W*c -: CHAN_W];
			e = cfg_end[COLOR_W-1-CHAN_W*c -: CHAN_W];
			row_level[c] = {s[7:0], 16'h0000};
			if (e >= s) begin
				quot = ((e - s) << FRAC_W) / height_eff;
				row_step[c] = quot[STEP_W-1:0];
			end else begin
				quot = ((s - e) << FRAC_W) / height_eff;
				neg = 32'd0 - quot;
				row_step[c] = neg[STEP_W-1:0];
			end
		end
	endtask

	// Work out the pixel that one accepted request produces and advance the raster.
	task automatic predict_pixel(input logic rst);
		int unsigned   width_eff;
		int unsigned   height_eff;
		logic          last_col;
		logic          last_row;
		logic [7:0]    v;
		raster_pixel_t px;
		width_eff  = clamp_dim(cfg_width);
		height_eff = clamp_dim(cfg_height);
		if (rst) begin
			col_pos = 0;
			row_pos = 0;
			reload_gradient();
		end
		last_col = (col_pos >= width_eff - 1);
		last_row = (row_pos >= height_eff - 1);
		px.word = {ALPHA_OPAQUE, 24'h000000};
		for (int c = 0; c < NUM_CH; c++) begin
			v = row_level[c][ACC_W-1:FRAC_W];
			if (row_pos == 0) begin
				v = brighten(v);
			end else if (last_row) begin
				// The bottom corners get the row shade and then the column bevel on top.
				v = shade(v);
				if (col_pos == 0) v = brighten(v);
				if (last_col) v = shade(v);
			end else begin
				if (col_pos == 0) v = brighten(v);
				else if (last_col) v = shade(v);
			end
			px.word[COLOR_W-1-CHAN_W*c -: CHAN_W] = v;
		end
		px.eor = last_col;
		px.eof = last_col && last_row;
		expected_pixels.push_back(px);
		if (!last_col) begin
			col_pos++;
		end else if (!last_row) begin
			col_pos = 0;
			row_pos++;
			for (int c = 0; c < NUM_CH; c++) begin
				row_level[c] = row_level[c] + row_step[c][ACC_W-1:0];
			end
		end else begin
			col_pos = 0;
			row_pos = 0;
			reload_gradient();
		end
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < MAX_REPORTS) begin
			$display("mismatch on pixel %0d, %s: got %h, expected %h",
				pixels_checked, field, got, want);
		end
		mismatches++;
	endtask

	// Offer one request, holding it until the transfer, then record its prediction.
	task automatic send_pixel_request(input logic rst);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		restart  <= rst;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		predict_pixel(rst);
	endtask

	// Stop offering and wait until every predicted pixel has come out.
	task automatic drain_pixels();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_START_COLOR:  cfg_start  = value;
			REG_END_COLOR:    cfg_end    = value;
			REG_FRAME_WIDTH:  cfg_width  = value[DIM_W-1:0];
			REG_FRAME_HEIGHT: cfg_height = value[DIM_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic program_frame(input logic [COLOR_W-1:0] top, input logic [COLOR_W-1:0] bottom,
			input logic [CFG_DATA_W-1:0] width, input logic [CFG_DATA_W-1:0] height);
		write_register(REG_START_COLOR, top);
		write_register(REG_END_COLOR, bottom);
		write_register(REG_FRAME_WIDTH, width);
		write_register(REG_FRAME_HEIGHT, height);
	endtask

	function automatic logic [COLOR_W-1:0] random_color();
		int unsigned pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) return '0;
		if (pick == 1) return '1;
		return COLOR_W'($urandom);
	endfunction

	// Mostly small frames, with the odd out-of-range or largest size.
	function automatic logic [CFG_DATA_W-1:0] random_dim();
		int unsigned     pick;
		logic [DIM_W-1:0] dim;
		pick = $urandom_range(0, 19);
		if (pick < 16)       dim = DIM_W'($urandom_range(2, 12));
		else if (pick == 16) dim = DIM_W'($urandom_range(0, 1));
		else if (pick == 17) dim = DIM_W'($urandom_range(4097, 8191));
		else if (pick == 18) dim = DIM_W'(MAX_DIM);
		else                 dim = DIM_W'(MIN_DIM);
		// Bits above the register width are sometimes set; they must be dropped.
		if ($urandom_range(0, 3) == 0) return {11'($urandom), dim};
		return {11'h000, dim};
	endfunction

	// Straight out of reset the raster runs on the default registers with no restart.
	task automatic test_reset_state();
		drain_pixels();
		repeat (2) send_pixel_request(1'b0);
	endtask

	// White fading to black on a tiny frame: saturation and both bottom corners.
	task automatic test_corner_bevel();
		drain_pixels();
		program_frame(24'hffffff, 24'h000000, 24'd2, 24'd3);
		send_pixel_request(1'b1);
		repeat (6) send_pixel_request(1'b0);
	endtask

	task automatic test_size_clamp();
		drain_pixels();
		program_frame(24'h80ff01, 24'h7f00fe, 24'd1, 24'd0);
		send_pixel_request(1'b1);
		repeat (3) send_pixel_request(1'b0);
	endtask

	// Shrink the width and grow the height partway through a frame, so the column
	// is on the new edge and the accumulators run past the end color and wrap.
	task automatic test_midframe_changes();
		drain_pixels();
		program_frame(24'h000000, 24'hffffff, 24'd4, 24'd2);
		send_pixel_request(1'b1);
		repeat (4) send_pixel_request(1'b0);
		drain_pixels();
		write_register(REG_FRAME_WIDTH, 24'd2);
		write_register(REG_FRAME_HEIGHT, 24'd9);
		repeat (6) send_pixel_request(1'b0);
	endtask

	// Bursts of mostly well-formed frames, with registers sometimes rewritten between them.
	task automatic test_random_raster(input int items);
		int          sent;
		int unsigned frame_pixels;
		int unsigned burst;
		logic        first_restart;
		sent = 0;
		while (sent < items) begin
			drain_pixels();
			if ($urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 1)) write_register(REG_START_COLOR, random_color());
				if ($urandom_range(0, 1)) write_register(REG_END_COLOR, random_color());
				if ($urandom_range(0, 1)) write_register(REG_FRAME_WIDTH, random_dim());
				if ($urandom_range(0, 1)) write_register(REG_FRAME_HEIGHT, random_dim());
			end
			frame_pixels = clamp_dim(cfg_width) * clamp_dim(cfg_height);
			burst = $urandom_range(1, (frame_pixels * 2 + 2 > 60) ? 60 : frame_pixels * 2 + 2);
			first_restart = ($urandom_range(0, 99) < 80);
			for (int i = 0; i < burst; i++) begin
				if (i == 0) send_pixel_request(first_restart);
				else send_pixel_request($urandom_range(0, 99) < 3);
			end
			sent += burst;
		end
	endtask

	// The start of a frame with rows at the widest size, reached through an oversized width.
	task automatic test_full_width_row();
		drain_pixels();
		program_frame(random_color(), random_color(), 24'd8191, 24'd2);
		send_pixel_request(1'b1);
		repeat (LONG_RUN) send_pixel_request(1'b0);
	endtask

	// The start of a tall frame at the largest height, two pixels to a row.
	task automatic test_full_height_column();
		drain_pixels();
		program_frame(random_color(), random_color(), 24'd2, 24'(MAX_DIM));
		send_pixel_request(1'b1);
		repeat (LONG_RUN) send_pixel_request(1'b0);
	endtask

	// The output side holds off while requests keep coming, so the input must stall.
	task automatic test_output_stall();
		drain_pixels();
		program_frame(random_color(), random_color(), 24'd5, 24'd4);
		stall_requests <= stall_requests + 1;
		send_pixel_request(1'b1);
		repeat (59) send_pixel_request(1'b0);
	endtask

	// Output ready, with per-cycle idling and long hold-offs on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready     <= 1'b0;
			stall_left    <= 0;
			stalls_served <= 0;
		end else if (stalls_served != stall_requests) begin
			stalls_served <= stall_requests;
			stall_left    <= STALL_CYCLES;
			out_ready     <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Compare every output transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("pixel with none predicted", pixel_word, '0);
			end else begin
				oldest_pixel = expected_pixels.pop_front();
				if (pixel_word !== oldest_pixel.word)
					report_mismatch("pixel_word", pixel_word, oldest_pixel.word);
				if (end_of_row !== oldest_pixel.eor)
					report_mismatch("end_of_row", 32'(end_of_row), 32'(oldest_pixel.eor));
				if (end_of_frame !== oldest_pixel.eof)
					report_mismatch("end_of_frame", 32'(end_of_frame), 32'(oldest_pixel.eof));
			end
			pixels_checked++;
		end
	end

	// End the run if neither side has made a transfer for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		for (int c = 0; c < NUM_CH; c++) begin
			row_level[c] = '0;
			row_step[c]  = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 24;
		recv_idle_pct = 69;
		test_reset_state();
		test_corner_bevel();
		test_size_clamp();
		test_midframe_changes();
		test_random_raster(380);

		send_idle_pct = 69;
		recv_idle_pct = 24;
		test_random_raster(380);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_full_width_row();
		test_full_height_column();
		test_output_stall();
		test_random_raster(380);

		drain_pixels();
		if (expected_pixels.size() != 0)
			report_mismatch("pixels never produced", expected_pixels.size(), 0);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

### gradient_bevel_texture_generator_top.f
src/gbt_pkg.sv
src/gbt_front.sv
src/gbt_divider.sv
src/gbt_back.sv
src/gradient_bevel_texture_generator_top.sv
tb/sv/testbench.sv
